### rtl/core/msp_pkg.sv
// msp_pkg: shared codes, field widths and the result record of the multi-stack pool
// no dependencies; imported by the controller and the top level
package msp_pkg;

  // fixed field widths of the stream payload
  localparam int unsigned SID_W    = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // operation kinds carried on s_tuser
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // one result beat handed from the controller to the output register
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  pop_value;
    logic                pool_full;
    logic                stack_now_empty;
  } msp_result_t;

endpackage

### rtl/core/msp_slot_mem.sv
// msp_slot_mem: single-port slot store, one word per slot holding {link, value}
// read data registered; no package dependencies
module msp_slot_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 37
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or registered read, one access a cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### rtl/core/msp_ctrl.sv
// msp_ctrl: stack tops, free-list head, fill count and the two-step sequencer
// depends on msp_pkg and drives the port of msp_slot_mem
module msp_ctrl
  import msp_pkg::*;
#(
  parameter int unsigned NUM_STACKS = 4,
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned PW         = $clog2(SLOTS + 1),
  parameter int unsigned AW         = $clog2(SLOTS)
) (
  input  logic                     clk,
  input  logic                     rst,
  // input beat
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     kind,
  input  logic [SID_W-1:0]         stack_id,
  input  logic [VALUE_W-1:0]       push_value,
  // result beat
  output logic                     res_valid,
  input  logic                     res_ready,
  output msp_result_t              res,
  // slot memory port
  output logic                     mem_en,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_addr,
  output logic [PW+DATA_WIDTH-1:0] mem_wdata,
  input  logic [PW+DATA_WIDTH-1:0] mem_rdata
);

  localparam int unsigned SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [PW-1:0] PTR_NULL = PW'(SLOTS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic          state;
  logic [PW-1:0] tops [NUM_STACKS];
  logic [PW-1:0] free_head;
  logic [PW-1:0] fill;

  // latched operation
  logic                  op_kind;
  logic                  op_sid_ok;
  logic [SW-1:0]         op_tsel;
  logic [DATA_WIDTH-1:0] op_value;
  logic [PW-1:0]         op_slot;
  logic                  op_ok;

  logic                  accept;
  logic                  sid_ok;
  logic [SW-1:0]         tsel;
  logic [PW-1:0]         slot;
  logic                  slot_ok;
  logic                  commit;
  logic [PW-1:0]         top_cur;
  logic [PW-1:0]         link_rd;
  logic [DATA_WIDTH-1:0] value_rd;
  logic [PW-1:0]         free_head_next;
  logic [PW-1:0]         top_next;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // slot addressed by the incoming beat
  assign sid_ok  = (32'(stack_id) < NUM_STACKS);
  assign tsel    = SW'(stack_id);
  assign slot    = (kind == KIND_PUSH) ? free_head : tops[tsel];
  assign slot_ok = sid_ok && (slot < PTR_NULL);

  // slots at or above the fill count were never written: their link is slot + 1
  assign value_rd = mem_rdata[DATA_WIDTH-1:0];
  assign link_rd  = (op_slot >= fill) ? (op_slot + 1'b1) : mem_rdata[PW+DATA_WIDTH-1:DATA_WIDTH];
  assign top_cur  = tops[op_tsel];

  assign commit    = (state == S_EXEC) && res_ready;
  assign res_valid = (state == S_EXEC);

  // new pointers after a successful operation
  always_comb begin
    free_head_next = free_head;
    top_next       = top_cur;
    if (op_ok) begin
      if (op_kind == KIND_PUSH) begin
        free_head_next = link_rd;
        top_next       = op_slot;
      end else begin
        free_head_next = op_slot;
        top_next       = link_rd;
      end
    end
  end

  // memory port: read on accept, write back on commit
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = AW'(slot);
    mem_wdata = {free_head, value_rd};
    if (accept) begin
      mem_en   = slot_ok;
      mem_addr = AW'(slot);
    end else if (commit) begin
      mem_en   = op_ok;
      mem_we   = 1'b1;
      mem_addr = AW'(op_slot);
      if (op_kind == KIND_PUSH) begin
        mem_wdata = {top_cur, op_value};
      end else begin
        mem_wdata = {free_head, value_rd};
      end
    end
  end

  // result fields
  always_comb begin
    res.status          = STATUS_DONE;
    res.pop_value       = '0;
    res.pool_full       = !(free_head_next < PTR_NULL);
    res.stack_now_empty = 1'b1;
    if (!op_ok) begin
      res.status = (op_kind == KIND_PUSH) ? STATUS_FULL : STATUS_EMPTY;
    end else if (op_kind == KIND_POP) begin
      res.pop_value = VALUE_W'(value_rd);
    end
    if (op_sid_ok) begin
      res.stack_now_empty = !(top_next < PTR_NULL);
    end
  end

  // sequencer and pointer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      fill      <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        tops[i] <= PTR_NULL;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state <= S_IDLE;
            if (op_ok) begin
              free_head     <= free_head_next;
              tops[op_tsel] <= top_next;
              if ((op_kind == KIND_PUSH) && (op_slot == fill)) begin
                fill <= fill + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // operation latch
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind   <= kind;
      op_sid_ok <= sid_ok;
      op_tsel   <= tsel;
      op_value  <= DATA_WIDTH'(push_value);
      op_slot   <= slot;
      op_ok     <= slot_ok;
    end
  end

endmodule

### rtl/core/multi_stack_shared_pool.sv
// multi_stack_shared_pool: top level, stream ports, output register
// depends on msp_pkg, msp_ctrl and msp_slot_mem
//
// Several LIFO stacks share one pool of SLOTS slots. Each input beat on the
// s_ group is a push (s_tuser = 0) or a pop (s_tuser = 1) on the stack named
// in s_tdata. Each beat yields exactly one result beat on the m_ group with a
// status code, the popped value, a pool-full flag and a stack-empty flag.
// A refused push (pool full or stack id out of range) or pop (stack empty or
// id out of range) changes nothing and reports its status.
// An item goes through a read step, which fetches the addressed slot word
// from the single-port slot memory, and a write-back step, which updates
// pointers and writes the word back. The result enters the output register
// as the write-back step completes, which waits while that register is
// full; a new input beat is taken only after that write-back.
// While m_tready is low, the output register holds its beat; one more input
// beat may be taken and waits at its write-back step until the register frees.
// Reset (rst, synchronous) empties all stacks and puts every slot on the free
// list at once; no clearing pass is needed, input is taken on the next cycle.
module multi_stack_shared_pool
  import msp_pkg::*;
#(
  parameter int unsigned NUM_STACKS = 4,
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // stack_id[1:0], push_value[33:2], zero pad
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // status[1:0], pop_value[33:2], pool_full[34],
                                 // stack_now_empty[35], zero pad
);

  localparam int unsigned PW = $clog2(SLOTS + 1);
  localparam int unsigned AW = $clog2(SLOTS);

  logic                     res_valid;
  logic                     res_ready;
  msp_result_t              res;
  msp_result_t              out_res;
  logic                     mem_en;
  logic                     mem_we;
  logic [AW-1:0]            mem_addr;
  logic [PW+DATA_WIDTH-1:0] mem_wdata;
  logic [PW+DATA_WIDTH-1:0] mem_rdata;

  msp_ctrl #(
    .NUM_STACKS(NUM_STACKS),
    .SLOTS     (SLOTS),
    .DATA_WIDTH(DATA_WIDTH),
    .PW        (PW),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .kind      (s_tuser),
    .stack_id  (s_tdata[1:0]),
    .push_value(s_tdata[33:2]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  msp_slot_mem #(
    .DEPTH(SLOTS),
    .WIDTH(PW + DATA_WIDTH)
  ) u_mem (
    .clk  (clk),
    .en   (mem_en),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // output register: loads when empty or when its beat is taken
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {4'b0000, out_res.stack_now_empty, out_res.pool_full,
                    out_res.pop_value, out_res.status};

endmodule

### tb/multi_stack_shared_pool_tb.sv
// multi_stack_shared_pool_tb: self-checking bench for the shared-pool multi-stack block
// depends on msp_pkg and multi_stack_shared_pool; an internal predictor checks every
// result beat; the stimulus is a directed table followed by random push and pop traffic
module multi_stack_shared_pool_tb;
  import msp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTK        = 4;
  localparam int NSLOT       = 16;
  localparam int PTR_W       = 5;
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NSLOT);
  localparam int RAND_ITEMS  = 1000;
  localparam int HOLD_CYCLES = 60;
  localparam int STUCK_LIMIT = 2000;

  typedef struct {
    logic        kind;
    logic [1:0]  sid;
    logic [31:0] value;
    bit          typed;
    msp_result_t want;
  } op_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // stack_id[1:0], push_value[33:2], zero pad
  logic        s_tuser = 1'b0; // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // status[1:0], pop_value[33:2], pool_full[34],
                               // stack_now_empty[35], zero pad

  // shadow of the pool kept by the predictor
  logic [31:0]      slot_data [NSLOT];
  logic [PTR_W-1:0] slot_link [NSLOT];
  logic [PTR_W-1:0] stack_top [NSTK];
  logic [PTR_W-1:0] free_slot;

  msp_result_t pending_results[$];
  op_row_t     directed_ops[$];
  int          mismatches = 0;
  int          hold_asks = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  bit          quiet = 1'b0;

  multi_stack_shared_pool uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // push or pop on the shadow pool, returns the result beat it should produce
  function automatic msp_result_t apply_op(input logic kind, input logic [1:0] sid,
                                           input logic [31:0] value);
    msp_result_t r;
    logic [PTR_W-1:0] s;
    r.status    = STATUS_DONE;
    r.pop_value = '0;
    if (kind == KIND_PUSH) begin
      if (free_slot >= NULL_PTR) begin
        r.status = STATUS_FULL;
      end else begin
        s = free_slot;
        free_slot = slot_link[s];
        slot_link[s] = stack_top[sid];
        stack_top[sid] = s;
        slot_data[s] = value;
      end
    end else begin
      if (stack_top[sid] >= NULL_PTR) begin
        r.status = STATUS_EMPTY;
      end else begin
        s = stack_top[sid];
        stack_top[sid] = slot_link[s];
        slot_link[s] = free_slot;
        free_slot = s;
        r.pop_value = slot_data[s];
      end
    end
    r.pool_full       = (free_slot >= NULL_PTR);
    r.stack_now_empty = (stack_top[sid] >= NULL_PTR);
    return r;
  endfunction

  function automatic msp_result_t mk_result(input logic [1:0] status, input logic [31:0] value,
                                            input logic full, input logic empty);
    msp_result_t r;
    r.status          = status;
    r.pop_value       = value;
    r.pool_full       = full;
    r.stack_now_empty = empty;
    return r;
  endfunction

  function automatic void add_row(input logic kind, input logic [1:0] sid,
                                  input logic [31:0] value, input bit typed,
                                  input msp_result_t want);
    op_row_t row;
    row.kind  = kind;
    row.sid   = sid;
    row.value = value;
    row.typed = typed;
    row.want  = want;
    directed_ops.push_back(row);
  endfunction

  // drive one beat, wait for the handshake, then record what it should produce
  task automatic send_op(input logic kind, input logic [1:0] sid, input logic [31:0] value,
                         input bit typed, input msp_result_t want);
    msp_result_t r;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {6'b0, value, sid};
    do @(posedge clk); while (!s_tready);
    r = apply_op(kind, sid, value);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // receiver readiness: random stall bursts, calm stretches, one long hold
  always @(negedge clk) begin : drive_ready
    int stall_left;
    int calm_left;
    int r;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
      calm_left = 0;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (quiet || calm_left > 0) begin
      if (calm_left > 0) calm_left = calm_left - 1;
      m_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 31);
      if (r < 4) begin
        stall_left = $urandom_range(0, 4);
        m_tready <= 1'b0;
      end else begin
        if (r == 4) calm_left = $urandom_range(20, 60);
        m_tready <= 1'b1;
      end
    end
  end

  // compare each result beat with the oldest pending prediction
  always @(posedge clk) begin : check_result
    msp_result_t got;
    msp_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got.status          = m_tdata[1:0];
      got.pop_value       = m_tdata[33:2];
      got.pool_full       = m_tdata[34];
      got.stack_now_empty = m_tdata[35];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result beat status=%0d value=%h full=%b empty=%b",
                   got.status, got.pop_value, got.pool_full, got.stack_now_empty);
      end else begin
        exp_r = pending_results.pop_front();
        if (got.status !== exp_r.status || got.pop_value !== exp_r.pop_value ||
            got.pool_full !== exp_r.pool_full ||
            got.stack_now_empty !== exp_r.stack_now_empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: expected status=%0d value=%h full=%b empty=%b, ",
                      "got status=%0d value=%h full=%b empty=%b"},
                     exp_r.status, exp_r.pop_value, exp_r.pool_full, exp_r.stack_now_empty,
                     got.status, got.pop_value, got.pool_full, got.stack_now_empty);
        end
      end
    end
  end

  // watchdog on cycles without any beat moving
  always @(posedge clk) begin : watchdog
    int stuck;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck = 0;
    end else begin
      stuck = stuck + 1;
      if (stuck >= STUCK_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : stimulus
    op_row_t     row;
    msp_result_t none;
    logic        kind;
    logic [1:0]  sid;
    logic [31:0] value;
    int seg_left;
    int push_pct;
    int idle_pct;

    none = mk_result(STATUS_DONE, '0, 1'b0, 1'b0);
    for (int i = 0; i < NSLOT; i++) begin
      slot_data[i] = '0;
      slot_link[i] = PTR_W'(i + 1);
    end
    for (int i = 0; i < NSTK; i++) stack_top[i] = NULL_PTR;
    free_slot = '0;

    // directed: pops on every empty stack, extreme values, pool fill-up and overflow
    for (int i = 0; i < NSTK; i++)
      add_row(KIND_POP, 2'(i), 32'h0, 1'b1, mk_result(STATUS_EMPTY, '0, 1'b0, 1'b1));
    add_row(KIND_PUSH, 2'd3, 32'h7fffffff, 1'b1, mk_result(STATUS_DONE, '0, 1'b0, 1'b0));
    add_row(KIND_PUSH, 2'd0, 32'h80000000, 1'b1, mk_result(STATUS_DONE, '0, 1'b0, 1'b0));
    add_row(KIND_POP, 2'd3, 32'hffffffff, 1'b1,
            mk_result(STATUS_DONE, 32'h7fffffff, 1'b0, 1'b1));
    add_row(KIND_POP, 2'd0, 32'h0, 1'b1, mk_result(STATUS_DONE, 32'h80000000, 1'b0, 1'b1));
    add_row(KIND_PUSH, 2'd1, 32'h0, 1'b1, mk_result(STATUS_DONE, '0, 1'b0, 1'b0));
    for (int i = 1; i < NSLOT; i++)
      add_row(KIND_PUSH, 2'(i), (i % 2) ? 32'h55555555 ^ i : 32'haaaaaaaa ^ i, 1'b0, none);
    add_row(KIND_PUSH, 2'd1, 32'hffffffff, 1'b1, mk_result(STATUS_FULL, '0, 1'b1, 1'b0));
    add_row(KIND_POP, 2'd2, 32'h0, 1'b0, none);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_ops[i]) begin
      row = directed_ops[i];
      if ($urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 5));
      send_op(row.kind, row.sid, row.value, row.typed, row.want);
    end

    // random: segments biased toward pushes or pops so the pool fills and drains
    seg_left = 0;
    push_pct = 50;
    idle_pct = 20;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 50);
        case ($urandom_range(0, 2))
          0:       push_pct = 25;
          1:       push_pct = 50;
          default: push_pct = 80;
        endcase
        idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
      end
      seg_left--;
      if (i == 300) hold_asks++;
      if (i == 600) begin
        pause_sender(1);
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (i == RAND_ITEMS - 150) quiet = 1'b1;
      if (!quiet && hold_left == 0 && hold_asks == hold_seen &&
          $urandom_range(0, 99) < idle_pct)
        pause_sender($urandom_range(1, 5));
      kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
      sid  = 2'($urandom_range(0, NSTK - 1));
      case ($urandom_range(0, 7))
        0:       value = 32'h7fffffff;
        1:       value = 32'h80000000;
        2:       value = 32'h00000000;
        3:       value = 32'hffffffff;
        default: value = $urandom;
      endcase
      send_op(kind, sid, value, 1'b0, none);
    end

    // drain and let any stray beat show up
    pause_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
